// ===== hdl/ccmfd_pkg.sv =====
package ccmfd_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned WORD_W = 16;
    localparam int unsigned POS_W = 4;
    localparam int unsigned VALUE_W = 15;
    localparam int unsigned PROD_W = 31;
    localparam int unsigned ERR_W = 2;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
    localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;

    localparam logic [POS_W-1:0] FRAME_BYTES = 4'd12;
    localparam logic [POS_W-1:0] LAST_POS = 4'd11;

    // Word order inside the frame.
    localparam logic [1:0] WORD_CO2 = 2'd0;
    localparam logic [1:0] WORD_TEMP = 2'd1;
    localparam logic [1:0] WORD_RH = 2'd2;
    localparam logic [1:0] WORD_STATUS = 2'd3;

    // Byte role inside one three-byte word group.
    localparam logic [1:0] PHASE_HIGH = 2'd0;
    localparam logic [1:0] PHASE_LOW = 2'd1;
    localparam logic [1:0] PHASE_CRC = 2'd2;

    localparam logic [ERR_W-1:0] ERR_OK = 2'd0;
    localparam logic [ERR_W-1:0] ERR_CRC = 2'd1;
    localparam logic [ERR_W-1:0] ERR_DISABLED = 2'd2;

    localparam logic [PROD_W-1:0] TEMP_SCALE = 31'd17500;
    localparam logic [PROD_W-1:0] RH_SCALE = 31'd12500;
    localparam logic [VALUE_W:0] TEMP_OFFSET = 16'd4500;
    localparam logic [VALUE_W:0] RH_OFFSET = 16'd600;
    localparam logic [WORD_W:0] FULL_SCALE = 17'd65535;

    typedef struct packed {
        logic [1:0] word;
        logic [1:0] phase;
    } pos_info_t;

    typedef struct packed {
        logic [WORD_W-1:0] co2_raw;
        logic [WORD_W-1:0] thermo_raw;
        logic [WORD_W-1:0] rh_raw;
        logic [WORD_W-1:0] status_raw;
        logic [ERR_W-1:0]  err;
    } frame_t;

    function automatic logic [BYTE_W-1:0] crc8_step(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] data);
        logic [BYTE_W-1:0] c;
        c = crc ^ data;
        for (int k = 0; k < BYTE_W; k++) begin
            c = c[BYTE_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    function automatic pos_info_t decode_pos(input logic [POS_W-1:0] pos);
        pos_info_t info;
        unique case (pos)
            4'd0:  info = '{word: WORD_CO2,    phase: PHASE_HIGH};
            4'd1:  info = '{word: WORD_CO2,    phase: PHASE_LOW};
            4'd2:  info = '{word: WORD_CO2,    phase: PHASE_CRC};
            4'd3:  info = '{word: WORD_TEMP,   phase: PHASE_HIGH};
            4'd4:  info = '{word: WORD_TEMP,   phase: PHASE_LOW};
            4'd5:  info = '{word: WORD_TEMP,   phase: PHASE_CRC};
            4'd6:  info = '{word: WORD_RH,     phase: PHASE_HIGH};
            4'd7:  info = '{word: WORD_RH,     phase: PHASE_LOW};
            4'd8:  info = '{word: WORD_RH,     phase: PHASE_CRC};
            4'd9:  info = '{word: WORD_STATUS, phase: PHASE_HIGH};
            4'd10: info = '{word: WORD_STATUS, phase: PHASE_LOW};
            4'd11: info = '{word: WORD_STATUS, phase: PHASE_CRC};
            default: info = '{word: WORD_CO2,  phase: PHASE_HIGH};
        endcase
        return info;
    endfunction

endpackage

// ===== hdl/ccmfd_front.sv =====
module ccmfd_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    input  logic                   cfg_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,
    input  logic                   s_tuser,
    input  logic                   push_ready,
    output logic                   push_valid,
    output ccmfd_pkg::frame_t      push_frame
);
    import ccmfd_pkg::*;

    logic              enabled_reg;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [BYTE_W-1:0] crc_reg, crc_next;
    logic              failed_reg, failed_next;
    logic [BYTE_W-1:0] high_reg, high_next;
    logic [BYTE_W-1:0] low_reg, low_next;
    logic [WORD_W-1:0] co2_reg, co2_next;
    logic [WORD_W-1:0] temp_reg, temp_next;
    logic [WORD_W-1:0] rh_reg, rh_next;

    logic [POS_W-1:0]  pos_eff;
    logic [BYTE_W-1:0] crc_cur;
    logic              failed_cur;
    pos_info_t         info;
    logic              accept;
    logic              last_byte;

    // The queue decides stalling; a byte is never held back otherwise.
    assign s_tready = push_ready;
    assign accept = s_tvalid && s_tready;

    always_comb begin
        pos_eff = s_tuser ? '0 : pos_reg;
        if (pos_eff >= FRAME_BYTES) begin
            pos_eff = '0;
        end
        crc_cur = s_tuser ? CRC_INIT : crc_reg;
        failed_cur = s_tuser ? 1'b0 : failed_reg;
        info = decode_pos(pos_eff);
        last_byte = (pos_eff == LAST_POS);

        crc_next = crc_cur;
        failed_next = failed_cur;
        high_next = high_reg;
        low_next = low_reg;
        co2_next = co2_reg;
        temp_next = temp_reg;
        rh_next = rh_reg;

        unique case (info.phase)
            PHASE_HIGH: begin
                high_next = s_tdata;
                crc_next = crc8_step(CRC_INIT, s_tdata);
            end
            PHASE_LOW: begin
                crc_next = crc8_step(crc_cur, s_tdata);
                unique case (info.word)
                    WORD_CO2:    co2_next = {high_reg, s_tdata};
                    WORD_TEMP:   temp_next = {high_reg, s_tdata};
                    WORD_RH:     rh_next = {high_reg, s_tdata};
                    WORD_STATUS: low_next = s_tdata;
                    default:     low_next = s_tdata;
                endcase
            end
            default: begin
                if (crc_cur != s_tdata) begin
                    failed_next = 1'b1;
                end
                crc_next = CRC_INIT;
            end
        endcase

        push_frame.co2_raw = co2_reg;
        push_frame.thermo_raw = temp_reg;
        push_frame.rh_raw = rh_reg;
        push_frame.status_raw = {high_reg, low_reg};
        if (!enabled_reg) begin
            push_frame.err = ERR_DISABLED;
        end else if (failed_next) begin
            push_frame.err = ERR_CRC;
        end else begin
            push_frame.err = ERR_OK;
        end

        if (last_byte) begin
            pos_next = '0;
            crc_next = CRC_INIT;
            failed_next = 1'b0;
        end else begin
            pos_next = pos_eff + 1'b1;
        end
    end

    assign push_valid = accept && last_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg <= 1'b0;
            pos_reg <= '0;
            crc_reg <= CRC_INIT;
            failed_reg <= 1'b0;
            high_reg <= '0;
            low_reg <= '0;
        end else begin
            if (cfg_valid) begin
                enabled_reg <= cfg_data;
            end
            if (accept) begin
                pos_reg <= pos_next;
                crc_reg <= crc_next;
                failed_reg <= failed_next;
                high_reg <= high_next;
                low_reg <= low_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            co2_reg <= co2_next;
            temp_reg <= temp_next;
            rh_reg <= rh_next;
        end
    end

endmodule

// ===== hdl/ccmfd_queue.sv =====
module ccmfd_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_valid,
    output logic               push_ready,
    input  ccmfd_pkg::frame_t  push_frame,
    output logic               pop_valid,
    input  logic               pop_ready,
    output ccmfd_pkg::frame_t  pop_frame
);
    import ccmfd_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);

    frame_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != DEPTH_CNT);
    assign pop_valid = (count_reg != '0);
    assign pop_frame = slot_reg[rd_ptr_reg];
    assign do_push = push_valid && push_ready;
    assign do_pop = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_frame;
        end
    end

endmodule

// ===== hdl/ccmfd_back.sv =====
module ccmfd_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  ccmfd_pkg::frame_t  pop_frame,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [63:0]        m_tdata,
    output logic [1:0]         m_tuser
);
    import ccmfd_pkg::*;

    // Multiply stage.
    logic               mul_valid_reg;
    logic [PROD_W-1:0]  temp_prod_reg;
    logic [PROD_W-1:0]  rh_prod_reg;
    logic [WORD_W-1:0]  co2_reg;
    logic [WORD_W-1:0]  status_reg;
    logic [ERR_W-1:0]   err_reg;

    // Output stage.
    logic               out_valid_reg;
    logic [WORD_W-1:0]  out_co2_reg, out_co2_next;
    logic [VALUE_W-1:0] out_temp_reg, out_temp_next;
    logic [VALUE_W-1:0] out_rh_reg, out_rh_next;
    logic [WORD_W-1:0]  out_status_reg, out_status_next;
    logic [ERR_W-1:0]   out_err_reg;

    logic               out_advance;
    logic               mul_load;
    logic [VALUE_W-1:0] temp_q;
    logic [VALUE_W-1:0] rh_q;
    logic [VALUE_W:0]   temp_val;
    logic [VALUE_W:0]   rh_val;

    // Quotient by 65535: take the product shifted by 16 as a first guess;
    // the remainder then stays below twice the divisor, so one correction is enough.
    function automatic logic [VALUE_W-1:0] div_full_scale(input logic [PROD_W-1:0] p);
        logic [VALUE_W-1:0] q0;
        logic [WORD_W:0]    r;
        q0 = p[PROD_W-1:WORD_W];
        r = {1'b0, p[WORD_W-1:0]} + {2'b00, q0};
        return (r >= FULL_SCALE) ? q0 + 1'b1 : q0;
    endfunction

    assign out_advance = !out_valid_reg || m_tready;
    assign mul_load = !mul_valid_reg || out_advance;
    assign pop_ready = mul_load;

    always_comb begin
        temp_q = div_full_scale(temp_prod_reg);
        rh_q = div_full_scale(rh_prod_reg);
        temp_val = {1'b0, temp_q} - TEMP_OFFSET;
        rh_val = {1'b0, rh_q} - RH_OFFSET;
        if (err_reg == ERR_OK) begin
            out_co2_next = co2_reg;
            out_temp_next = temp_val[VALUE_W-1:0];
            out_rh_next = rh_val[VALUE_W-1:0];
            out_status_next = status_reg;
        end else begin
            out_co2_next = '0;
            out_temp_next = '0;
            out_rh_next = '0;
            out_status_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (mul_load) begin
                mul_valid_reg <= pop_valid;
            end
            if (out_advance) begin
                out_valid_reg <= mul_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mul_load) begin
            temp_prod_reg <= TEMP_SCALE * {15'd0, pop_frame.thermo_raw};
            rh_prod_reg <= RH_SCALE * {15'd0, pop_frame.rh_raw};
            co2_reg <= pop_frame.co2_raw;
            status_reg <= pop_frame.status_raw;
            err_reg <= pop_frame.err;
        end
        if (out_advance) begin
            out_co2_reg <= out_co2_next;
            out_temp_reg <= out_temp_next;
            out_rh_reg <= out_rh_next;
            out_status_reg <= out_status_next;
            out_err_reg <= err_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {2'b00, out_status_reg, out_rh_reg, out_temp_reg, out_co2_reg};
    assign m_tuser = out_err_reg;

endmodule

// ===== hdl/crc_checked_measurement_frame_decoder.sv =====
// Receives a 12-byte measurement frame one byte per transaction: four big-endian
// words (CO2, temperature, humidity, status), each followed by a CRC-8 (poly 0x31,
// init 0xFF). The input takes one byte every clock cycle; it stalls only when two
// finished frames are already queued behind an output that is not being drained.
// s_tuser marks the first byte of a frame, and after the twelfth byte the next byte
// starts a new frame on its own. After the frame's last byte is taken, its result
// passes the queue slot, the constant multiply stage, the divide-by-65535 correction
// and the output register. On a CRC error or while measurement is disabled all value
// fields are zero and the error code tells why; disabled takes precedence. The enable
// bit is written through the cfg channel, which is always ready.
module crc_checked_measurement_frame_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,     // measuring_enabled
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // [7:0] rx_byte
    input  logic        s_tuser,      // [0] frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,      // [15:0] co2_ppm, [30:16] temp_centi_c,
                                      // [45:31] rh_centi_pct, [61:46] sensor_status,
                                      // zero pad
    output logic [1:0]  m_tuser       // [1:0] error_code
);
    import ccmfd_pkg::*;

    logic   push_valid;
    logic   push_ready;
    frame_t push_frame;
    logic   pop_valid;
    logic   pop_ready;
    frame_t pop_frame;

    assign cfg_ready = 1'b1;

    ccmfd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_frame (push_frame)
    );

    ccmfd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_frame (push_frame),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_frame  (pop_frame)
    );

    ccmfd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_frame (pop_frame),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== tb/tb_crc_checked_measurement_frame_decoder.sv =====
module tb_crc_checked_measurement_frame_decoder;
    import ccmfd_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 12;
    localparam int RANDOM_BYTES = 600;
    localparam int RANDOM_PHASES = 7;
    localparam int MAX_REPORTS = 10;
    localparam int unsigned TEMP_SPAN = 17500;
    localparam int unsigned RH_SPAN = 12500;
    localparam int unsigned RAW_FULL = 65535;
    localparam int TEMP_BASE = 4500;
    localparam int RH_BASE = 600;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              frame_start;
    } rx_item_t;

    typedef struct packed {
        logic [WORD_W-1:0]  co2;
        logic [VALUE_W-1:0] temp;
        logic [VALUE_W-1:0] rh;
        logic [WORD_W-1:0]  status;
        logic [ERR_W-1:0]   err;
    } reading_t;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_PERIODIC
    } ready_mode_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_data = 1'b0;
    logic        cfg_ready;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tuser = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;

    // Model of the receiver, advanced on every accepted byte.
    logic [POS_W-1:0]  frame_pos = '0;
    logic [BYTE_W-1:0] crc_acc = CRC_INIT;
    logic [BYTE_W-1:0] hi_byte = '0;
    logic [BYTE_W-1:0] lo_byte = '0;
    logic [WORD_W-1:0] words [3];
    logic              crc_bad = 1'b0;
    logic              enabled = 1'b0;

    rx_item_t rx_pending [$];
    reading_t readings_due [$];
    int bytes_queued = 0;
    int mismatches = 0;
    int idle_cycles = 0;
    int burst_left = 0;
    int gap_left = 0;
    int ready_left = 0;
    ready_mode_t ready_mode = READY_ALWAYS;
    bit s_taken = 1'b0;
    bit cfg_taken = 1'b0;

    crc_checked_measurement_frame_decoder i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial forever #2 aclk = ~aclk;

    function automatic logic [BYTE_W-1:0] crc8_next(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] data);
        logic [BYTE_W-1:0] acc;
        acc = crc ^ data;
        repeat (BYTE_W) begin
            if (acc[BYTE_W-1]) begin
                acc = (acc << 1) ^ CRC_POLY;
            end else begin
                acc = acc << 1;
            end
        end
        return acc;
    endfunction

    // Advances the receiver model by one byte; returns 1 when the byte closes a frame.
    function automatic bit take_byte(input logic [BYTE_W-1:0] rx, input logic start,
                                     output reading_t res);
        int unsigned pos_now;
        int unsigned word_idx;
        logic [1:0] phase;
        int scaled;
        res = '0;
        if (start) begin
            frame_pos = '0;
            crc_acc = CRC_INIT;
            crc_bad = 1'b0;
        end
        pos_now = frame_pos;
        word_idx = pos_now / 3;
        phase = 2'(pos_now % 3);
        case (phase)
            PHASE_HIGH: begin
                hi_byte = rx;
                crc_acc = crc8_next(CRC_INIT, rx);
            end
            PHASE_LOW: begin
                crc_acc = crc8_next(crc_acc, rx);
                if (word_idx < 3) begin
                    words[word_idx] = {hi_byte, rx};
                end else begin
                    lo_byte = rx;
                end
            end
            default: begin
                if (crc_acc != rx) begin
                    crc_bad = 1'b1;
                end
                crc_acc = CRC_INIT;
            end
        endcase
        if (pos_now < LAST_POS) begin
            frame_pos = POS_W'(pos_now + 1);
            return 1'b0;
        end
        if (!enabled) begin
            res.err = ERR_DISABLED;
        end else if (crc_bad) begin
            res.err = ERR_CRC;
        end else begin
            res.err = ERR_OK;
            res.co2 = words[WORD_CO2];
            scaled = int'((TEMP_SPAN * words[WORD_TEMP]) / RAW_FULL) - TEMP_BASE;
            res.temp = scaled[VALUE_W-1:0];
            scaled = int'((RH_SPAN * words[WORD_RH]) / RAW_FULL) - RH_BASE;
            res.rh = scaled[VALUE_W-1:0];
            res.status = {hi_byte, lo_byte};
        end
        frame_pos = '0;
        crc_acc = CRC_INIT;
        crc_bad = 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [WORD_W-1:0] random_word();
        case ($urandom_range(0, 11))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            3: return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_byte(input logic [BYTE_W-1:0] rx, input logic start);
        rx_pending.push_back('{rx_byte: rx, frame_start: start});
        bytes_queued++;
    endtask

    // Queues the first n_bytes of a frame; set bits of bad_crc corrupt that word's CRC.
    task automatic queue_frame(input logic [WORD_W-1:0] co2, input logic [WORD_W-1:0] temp,
                               input logic [WORD_W-1:0] rh, input logic [WORD_W-1:0] status,
                               input logic [3:0] bad_crc, input bit start, input int n_bytes);
        logic [WORD_W-1:0] w [4];
        logic [BYTE_W-1:0] frame_bytes [12];
        logic [BYTE_W-1:0] crc;
        w = '{co2, temp, rh, status};
        for (int i = 0; i < 4; i++) begin
            crc = crc8_next(crc8_next(CRC_INIT, w[i][15:8]), w[i][7:0]);
            if (bad_crc[i]) begin
                crc ^= 8'($urandom_range(1, 255));
            end
            frame_bytes[3*i] = w[i][15:8];
            frame_bytes[3*i+1] = w[i][7:0];
            frame_bytes[3*i+2] = crc;
        end
        for (int k = 0; k < n_bytes; k++) begin
            queue_byte(frame_bytes[k], start && (k == 0));
        end
    endtask

    // Holds off until every byte is taken and every reading has come out, then lets
    // the pipeline run dry.
    task automatic settle();
        do @(posedge aclk); while (rx_pending.size() != 0 || s_tvalid);
        do @(negedge aclk); while (readings_due.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic set_enable(input logic value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(negedge aclk); while (!cfg_taken);
        cfg_valid <= 1'b0;
    endtask

    // Byte driver: bursts of random length separated by random gaps.
    always @(negedge aclk) begin
        rx_item_t item;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_taken) begin
            if (gap_left > 0 || rx_pending.size() == 0) begin
                if (gap_left > 0) begin
                    gap_left--;
                end
                s_tvalid <= 1'b0;
            end else begin
                item = rx_pending.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= item.rx_byte;
                s_tuser <= item.frame_start;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end
        end
    end

    // Result sink: the stall pattern switches between a few modes.
    always @(negedge aclk) begin
        if (ready_left == 0) begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            ready_left = $urandom_range(20, 120);
        end else begin
            ready_left--;
        end
        case (ready_mode)
            READY_ALWAYS:   m_tready <= 1'b1;
            READY_COIN:     m_tready <= 1'($urandom_range(0, 1));
            READY_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
            default:        m_tready <= (ready_left % 5) != 0;
        endcase
    end

    always @(posedge aclk) begin
        reading_t want;
        reading_t got;
        if (!aresetn) begin
            s_taken = 1'b0;
            cfg_taken = 1'b0;
        end else begin
            cfg_taken = cfg_valid && cfg_ready;
            s_taken = s_tvalid && s_tready;
            if (cfg_taken) begin
                enabled = cfg_data;
            end
            if (s_taken && take_byte(s_tdata, s_tuser, want)) begin
                readings_due.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got = '{co2: m_tdata[15:0], temp: m_tdata[30:16], rh: m_tdata[45:31],
                        status: m_tdata[61:46], err: m_tuser};
                if (readings_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display({"unexpected reading: ",
                                  "co2=%0d temp=%0d rh=%0d status=%04h err=%0d"},
                                 $signed(got.co2), $signed(got.temp), $signed(got.rh),
                                 got.status, got.err);
                    end
                end else begin
                    want = readings_due.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display({"reading mismatch: expected ",
                                      "co2=%0d temp=%0d rh=%0d status=%04h err=%0d"},
                                     $signed(want.co2), $signed(want.temp),
                                     $signed(want.rh), want.status, want.err);
                            $display({"                  actual   ",
                                      "co2=%0d temp=%0d rh=%0d status=%04h err=%0d"},
                                     $signed(got.co2), $signed(got.temp),
                                     $signed(got.rh), got.status, got.err);
                        end
                    end
                end
            end
            if (cfg_taken || s_taken || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb_crc_checked_measurement_frame_decoder NOT OK");
                $finish;
            end
        end
    end

    initial begin
        int bytes_goal;
        int pick;
        bit force_start;
        force_start = 1'b1;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Measurement still off after reset: a clean frame, then one that also has a
        // bad CRC and arrives through the wrap without a start mark.
        queue_frame(16'h01F4, 16'h6666, 16'h8000, 16'h0000, 4'b0000, 1'b1, 12);
        queue_frame(random_word(), random_word(), random_word(), random_word(),
                    4'b0010, 1'b0, 12);
        set_enable(1'b1);

        queue_frame(16'h8000, 16'hFFFF, 16'h0000, 16'hFFFF, 4'b0000, 1'b1, 12);
        queue_frame(16'h7FFF, 16'h0000, 16'hFFFF, 16'h0000, 4'b0000, 1'b0, 12);
        // A bad CRC on the first word must stick through three good words.
        queue_frame(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 4'b0001, 1'b1, 12);
        queue_frame(16'h0400, 16'h4000, 16'hC000, 16'hA5A5, 4'b1000, 1'b0, 12);
        // Aborted frame with a CRC error, then a restart that must clear the error.
        queue_frame(random_word(), random_word(), random_word(), random_word(),
                    4'b0001, 1'b1, 7);
        queue_frame(16'h0320, 16'h7A00, 16'h5500, 16'h0001, 4'b0000, 1'b1, 12);
        queue_frame(random_word(), random_word(), random_word(), random_word(),
                    4'b0000, 1'b1, 12);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            set_enable((p % 3) != 2);
            bytes_goal = bytes_queued + RANDOM_BYTES / RANDOM_PHASES;
            while (bytes_queued < bytes_goal) begin
                pick = $urandom_range(0, 9);
                if (pick < 8) begin
                    queue_frame(random_word(), random_word(), random_word(), random_word(),
                                ($urandom_range(0, 3) == 0) ? 4'($urandom_range(1, 15)) : 4'b0,
                                force_start || ($urandom_range(0, 1) == 1), 12);
                    force_start = 1'b0;
                end else if (pick == 8) begin
                    queue_frame(random_word(), random_word(), random_word(), random_word(),
                                4'($urandom), 1'b1, $urandom_range(1, 11));
                    force_start = 1'b1;
                end else begin
                    repeat ($urandom_range(1, 8)) begin
                        queue_byte(8'($urandom), $urandom_range(0, 5) == 0);
                    end
                    force_start = 1'b1;
                end
            end
        end

        settle();
        if (mismatches == 0 && readings_due.size() == 0) begin
            $display("tb_crc_checked_measurement_frame_decoder OK");
        end else begin
            $display("tb_crc_checked_measurement_frame_decoder NOT OK");
        end
        $finish;
    end

endmodule
